>>> hdl/cdg_pkg.sv
// Shared constants and types for the central difference gradient block.
`default_nettype none

package cdg_pkg;

	// Configuration port layout.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Register widths and their values after reset.
	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 16;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

	// Fixed widths of the row and column fields of a result word.
	localparam int ROW_W = 16;
	localparam int COL_W = 12;

	// Results still owed for one input word: the pixel above it, the pixel to its
	// left on the last row, and the final pixel of the frame.
	typedef struct packed {
		logic flush;
		logic left;
		logic above;
	} res_mask_t;

endpackage

`default_nettype wire

>>> hdl/cdg_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module cdg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// The read data holds until the next read.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/central_difference_gradient.sv
// Top level of the streaming central difference image gradient.
//
// Smoothed pixels enter on the s_ channel in raster order, one word per pixel.
// For each pixel the block returns a result word on the m_ channel with its
// row and column, the horizontal and vertical central differences and the
// squared gradient magnitude. Results describe the row above the incoming one,
// so a row's results appear while the next row streams in; inputs of row 0
// give no word. On the last row every pixel also returns the result for its
// left neighbor, and the final pixel of the frame returns its own as well.
// m_tlast marks the last result word that one input word causes.
// Result words leave the magnitude stage through the output register. One
// input word is taken per cycle while s_tready is high; on the last row a
// pixel causes up to three result words and the single output port then sets
// the pace. A line store of MAX_WIDTH entries holds the two earlier rows side
// by side; it is read two columns ahead, so one read and one write a cycle do.
// Reset clears the counters, the pipeline and the output register and loads
// the default image size; the line store keeps whatever it held and is never
// cleared. A write on the configuration port restarts the frame at row 0.
// When the receiver stalls, the pipeline fills and s_tready falls.
`default_nettype none

module central_difference_gradient #(
	parameter int MAX_WIDTH  = 4096,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	// Configuration write port.
	input  wire logic                                       cfg_we,
	input  wire logic [cdg_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  wire logic [cdg_pkg::CFG_DATA_W-1:0]             cfg_data,
	// Pixel stream in.
	input  wire logic                                       s_tvalid,
	output logic                                            s_tready,
	// tdata: pixel.
	input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]            s_tdata,
	// Result stream out.
	output logic                                            m_tvalid,
	input  wire logic                                       m_tready,
	// tdata: row, col, grad_x, grad_y, magnitude_sq, zero padding.
	output logic      [((4*PIXEL_BITS+31+7)/8)*8-1:0]       m_tdata,
	// tlast: last_of_run.
	output logic                                            m_tlast
);

	import cdg_pkg::*;

	localparam int PB       = PIXEL_BITS;
	localparam int AW       = $clog2(MAX_WIDTH);
	localparam int WW       = $clog2(MAX_WIDTH + 1);
	localparam int GW       = PB + 1;
	localparam int SQW      = 2 * PB;
	localparam int MW       = 2 * PB + 1;
	localparam int OUT_BITS = ROW_W + COL_W + 2 * GW + MW;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Configuration registers and frame position.
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [ROW_W-1:0]        row_q;
	logic [AW-1:0]           col_q;
	logic [WW-1:0]           w_eff;
	logic [WW-1:0]           w_last;
	logic [ROW_W-1:0]        h_eff;
	logic [ROW_W-1:0]        h_last;
	logic                    c_last;
	logic                    r_last;

	// Line store access. A word holds the older row in its upper half and the
	// previous row in its lower half.
	logic                    acc;
	logic [PB-1:0]           pixel;
	logic [AW:0]             ahead;
	logic [AW-1:0]           rd_addr;
	logic [2*PB-1:0]         rd_word;
	logic [2*PB-1:0]         cur_q;
	logic [PB-1:0]           left_q;
	logic [PB-1:0]           pix_d1_q;
	logic [PB-1:0]           pix_d2_q;

	logic signed [GW-1:0]    gxa;
	logic signed [GW-1:0]    gya;
	logic signed [GW-1:0]    gxb;
	res_mask_t               mask_in;

	// Stage 1: differences.
	logic                    valid_s1;
	res_mask_t               mask_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [ROW_W-1:0]        row_m1_s1;
	logic [AW-1:0]           col_s1;
	logic [AW-1:0]           col_m1_s1;
	logic signed [GW-1:0]    gxa_s1;
	logic signed [GW-1:0]    gya_s1;
	logic signed [GW-1:0]    gxb_s1;

	// Stage 2: squares.
	logic                    valid_s2;
	res_mask_t               mask_s2;
	logic [ROW_W-1:0]        row_s2;
	logic [ROW_W-1:0]        row_m1_s2;
	logic [AW-1:0]           col_s2;
	logic [AW-1:0]           col_m1_s2;
	logic signed [GW-1:0]    gxa_s2;
	logic signed [GW-1:0]    gya_s2;
	logic signed [GW-1:0]    gxb_s2;
	logic signed [2*GW-1:0]  prod_ax;
	logic signed [2*GW-1:0]  prod_ay;
	logic signed [2*GW-1:0]  prod_b;
	logic [SQW-1:0]          sq_ax_s2;
	logic [SQW-1:0]          sq_ay_s2;
	logic [SQW-1:0]          sq_b_s2;

	// Stage 3: magnitudes, drained by the result serializer.
	logic                    valid_s3;
	res_mask_t               mask_s3;
	logic [ROW_W-1:0]        row_s3;
	logic [ROW_W-1:0]        row_m1_s3;
	logic [AW-1:0]           col_s3;
	logic [AW-1:0]           col_m1_s3;
	logic signed [GW-1:0]    gxa_s3;
	logic signed [GW-1:0]    gya_s3;
	logic signed [GW-1:0]    gxb_s3;
	logic [MW-1:0]           mag_a_s3;
	logic [MW-1:0]           mag_b_s3;

	// Serializer and output register.
	logic                    out_ready;
	logic                    emit;
	logic                    adv3;
	logic                    en1;
	logic                    en2;
	logic                    en3;
	res_mask_t               remain;
	logic [ROW_W-1:0]        sel_row;
	logic [COL_W-1:0]        sel_col;
	logic signed [GW-1:0]    sel_gx;
	logic signed [GW-1:0]    sel_gy;
	logic [MW-1:0]           sel_mag;

	logic                    out_valid_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [COL_W-1:0]        out_col_q;
	logic signed [GW-1:0]    out_gx_q;
	logic signed [GW-1:0]    out_gy_q;
	logic [MW-1:0]           out_mag_q;
	logic                    out_last_q;

	// Effective image size: width held to 3..MAX_WIDTH, height to at least 2.
	always_comb begin
		priority if (width_q < WIDTH_REG_W'(3)) begin
			w_eff = WW'(3);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff  = (height_q < HEIGHT_REG_W'(2)) ? ROW_W'(2) : height_q;
		w_last = w_eff - WW'(1);
		h_last = h_eff - ROW_W'(1);
		c_last = (WW'(col_q) == w_last);
		r_last = (row_q == h_last);
	end

	assign acc   = s_tvalid && s_tready;
	assign pixel = s_tdata[PB-1:0];

	// The read runs two columns ahead and wraps into the next row, so the entry
	// for the next column is already in the read register when its pixel comes.
	always_comb begin
		ahead = (AW+1)'(col_q) + (AW+1)'(2);
		if (ahead >= (AW+1)'(w_eff)) begin
			ahead = ahead - (AW+1)'(w_eff);
		end
		rd_addr = ahead[AW-1:0];
	end

	cdg_ram #(
		.WIDTH(2 * PB),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (acc),
		.waddr(col_q),
		.wdata({cur_q[PB-1:0], pixel}),
		.re   (acc),
		.raddr(rd_addr),
		.rdata(rd_word)
	);

	// rd_word holds the next column's entry, cur_q this column's, left_q the
	// previous row's pixel one column to the left.
	always_ff @(posedge clk) begin
		if (acc) begin
			cur_q  <= rd_word;
			left_q <= cur_q[PB-1:0];
		end
	end

	// Differences for the pixel above and, on the last row, for the pixel to
	// the left.
	always_comb begin
		gxa = '0;
		gya = '0;
		gxb = '0;
		if (col_q != '0 && !c_last) begin
			gxa = $signed({1'b0, rd_word[PB-1:0]}) - $signed({1'b0, left_q});
		end
		if (row_q >= ROW_W'(2)) begin
			gya = $signed({1'b0, pixel}) - $signed({1'b0, cur_q[2*PB-1:PB]});
		end
		if (col_q >= AW'(2)) begin
			gxb = $signed({1'b0, pixel}) - $signed({1'b0, pix_d2_q});
		end
		mask_in.above = (row_q != '0);
		mask_in.left  = r_last && (col_q != '0);
		mask_in.flush = r_last && c_last;
	end

	// Configuration, frame position and the last two pixels of the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			row_q    <= '0;
			col_q    <= '0;
			pix_d1_q <= '0;
			pix_d2_q <= '0;
		end else begin
			priority if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= WIDTH_REG_W'(cfg_data);
					REG_IMAGE_HEIGHT: height_q <= HEIGHT_REG_W'(cfg_data);
				endcase
				row_q <= '0;
				col_q <= '0;
			end else if (acc) begin
				pix_d1_q <= pixel;
				pix_d2_q <= pix_d1_q;
				if (c_last) begin
					col_q <= '0;
					row_q <= r_last ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end else begin
				// No word arrives, so the position holds.
			end
		end
	end

	// Pipeline flow. A stage loads when it is empty or its contents move on.
	assign out_ready = !out_valid_q || m_tready;
	assign emit      = valid_s3 && out_ready;

	always_comb begin
		remain = mask_s3;
		priority if (mask_s3.above) begin
			remain.above = 1'b0;
		end else if (mask_s3.left) begin
			remain.left = 1'b0;
		end else begin
			remain.flush = 1'b0;
		end
	end

	assign adv3     = emit && (remain == '0);
	assign en3      = !valid_s3 || adv3;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			mask_s3     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= acc && (mask_in != '0);
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
				mask_s3  <= mask_s2;
			end else if (emit) begin
				mask_s3 <= remain;
			end
			if (out_ready) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	assign prod_ax = gxa_s1 * gxa_s1;
	assign prod_ay = gya_s1 * gya_s1;
	assign prod_b  = gxb_s1 * gxb_s1;

	always_ff @(posedge clk) begin
		if (en1 && acc) begin
			mask_s1   <= mask_in;
			row_s1    <= row_q;
			row_m1_s1 <= row_q - ROW_W'(1);
			col_s1    <= col_q;
			col_m1_s1 <= col_q - AW'(1);
			gxa_s1    <= gxa;
			gya_s1    <= gya;
			gxb_s1    <= gxb;
		end
		if (en2 && valid_s1) begin
			mask_s2   <= mask_s1;
			row_s2    <= row_s1;
			row_m1_s2 <= row_m1_s1;
			col_s2    <= col_s1;
			col_m1_s2 <= col_m1_s1;
			gxa_s2    <= gxa_s1;
			gya_s2    <= gya_s1;
			gxb_s2    <= gxb_s1;
			sq_ax_s2  <= prod_ax[SQW-1:0];
			sq_ay_s2  <= prod_ay[SQW-1:0];
			sq_b_s2   <= prod_b[SQW-1:0];
		end
		if (en3 && valid_s2) begin
			row_s3    <= row_s2;
			row_m1_s3 <= row_m1_s2;
			col_s3    <= col_s2;
			col_m1_s3 <= col_m1_s2;
			gxa_s3    <= gxa_s2;
			gya_s3    <= gya_s2;
			gxb_s3    <= gxb_s2;
			mag_a_s3  <= MW'(sq_ax_s2) + MW'(sq_ay_s2);
			mag_b_s3  <= MW'(sq_b_s2);
		end
	end

	// Result words go out in order: the pixel above, the left neighbor on the
	// last row, then the final pixel of the frame.
	always_comb begin
		priority if (mask_s3.above) begin
			sel_row = row_m1_s3;
			sel_col = COL_W'(col_s3);
			sel_gx  = gxa_s3;
			sel_gy  = gya_s3;
			sel_mag = mag_a_s3;
		end else if (mask_s3.left) begin
			sel_row = row_s3;
			sel_col = COL_W'(col_m1_s3);
			sel_gx  = gxb_s3;
			sel_gy  = '0;
			sel_mag = mag_b_s3;
		end else begin
			sel_row = row_s3;
			sel_col = COL_W'(col_s3);
			sel_gx  = '0;
			sel_gy  = '0;
			sel_mag = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q  <= sel_row;
			out_col_q  <= sel_col;
			out_gx_q   <= sel_gx;
			out_gy_q   <= sel_gy;
			out_mag_q  <= sel_mag;
			out_last_q <= (remain == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_W'({out_mag_q, out_gy_q, out_gx_q, out_col_q, out_row_q});

	// A word in the last stage always owes at least one result.
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (mask_s3 != '0))
		else $error("last stage holds a word with no results owed");

	// The look-ahead read never hits the entry written in the same cycle.
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (rd_addr != col_q))
		else $error("line store read and write collide");

	// The column counter stays inside the row.
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < w_eff))
		else $error("column counter beyond the image width");

	// A taken word that does not end its run is followed by the next one.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("result run broken before its last word");

endmodule

`default_nettype wire
